// ===== hw/rtl/sws_pkg.sv =====
// ----------------------------------------------------------------------------
// sws_pkg
// shared codes, widths and control structs of the searchable stack
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int NAME_W  = 64;
  localparam int VALUE_W = 32;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 2;

  localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOWEST  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HIGHEST = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic ready;
    logic exec;
    logic push;
    logic pop;
    logic take_pop;
    logic scan_first;
    logic scan_step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              req_valid;
    logic              empty;
    logic              full;
    logic              scan_last;
    logic              out_free;
  } sts_t;

endpackage

// ===== hw/rtl/sws_if.sv =====
// ----------------------------------------------------------------------------
// sws_req_if / sws_res_if
// valid/ready channels for requests and results of the searchable stack
// ----------------------------------------------------------------------------
interface sws_req_if;
  logic                              valid;
  logic                              ready;
  logic [sws_pkg::MODE_W-1:0]        mode;
  logic [sws_pkg::NAME_W-1:0]        name_key;
  logic signed [sws_pkg::VALUE_W-1:0] value_in;

  modport source (output valid, mode, name_key, value_in, input ready);
  modport sink   (input valid, mode, name_key, value_in, output ready);
endinterface

interface sws_res_if #(
  parameter int DEPTH_W = 5
);
  logic                              valid;
  logic                              ready;
  logic [sws_pkg::STAT_W-1:0]        status;
  logic [sws_pkg::NAME_W-1:0]        name_out;
  logic signed [sws_pkg::VALUE_W-1:0] value_out;
  logic [DEPTH_W-1:0]                depth;

  modport source (output valid, status, name_out, value_out, depth, input ready);
  modport sink   (input valid, status, name_out, value_out, depth, output ready);
endinterface

// ===== hw/rtl/stack_with_search_and_extremes_unit.sv =====
// ----------------------------------------------------------------------------
// stack_with_search_and_extremes_unit
// bounded stack of key/value entries with push, pop, key search and
// lowest/highest value scan
//
//   channel   dir  handshake      payload
//   request   in   valid/ready    mode, name_key, value_in
//   result    out  valid/ready    status, name_out, value_out, depth
//
// push goes from exec to done, pop through a read state, search,
// lowest and highest through a scan state; empty-stack and spare-mode
// requests go from exec to done; a scan reads one stored entry per cycle
// from the single-port entry ram, so the held depth sets its length
// result sits in an output register: the next request is taken while it waits
// reset empties the stack; entry ram contents need no clearing
// ----------------------------------------------------------------------------
module stack_with_search_and_extremes_unit #(
  parameter int STACK_DEPTH = 16,
  parameter int NAME_BYTES  = 8
) (
  input  logic      clk,
  input  logic      rst,
  sws_req_if.sink   request,
  sws_res_if.source result
);

  sws_pkg::cmd_t cmd;
  sws_pkg::sts_t sts;

  sws_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  sws_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .NAME_BYTES  (NAME_BYTES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .result  (result),
    .cmd     (cmd),
    .sts     (sts)
  );

  a_depth_bound : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.depth <= STACK_DEPTH))
    else $error("result depth above stack depth");

  a_full_depth : assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == sws_pkg::ST_FULL) |-> (result.depth == STACK_DEPTH))
    else $error("full status with stack not full");

  a_empty_zero : assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == sws_pkg::ST_EMPTY) |->
      (result.depth == 0 && result.name_out == 0 && result.value_out == 0))
    else $error("empty status with data or depth");

  a_one_request : assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready) |=> !request.ready)
    else $error("request taken while busy");

endmodule

// ===== hw/rtl/sws_ram.sv =====
// ----------------------------------------------------------------------------
// sws_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module sws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/sws_ctrl.sv =====
// ----------------------------------------------------------------------------
// sws_ctrl
// command sequencer: accept, execute, read or scan, then hand off the result
// ----------------------------------------------------------------------------
module sws_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  sws_pkg::sts_t sts,
  output sws_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (sts.req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_DONE;
        case (sts.mode)
          sws_pkg::MODE_PUSH: begin
            cmd.push = !sts.full;
          end
          sws_pkg::MODE_POP: begin
            if (!sts.empty) begin
              cmd.pop    = 1'b1;
              state_next = S_READ;
            end
          end
          sws_pkg::MODE_SEARCH, sws_pkg::MODE_LOWEST, sws_pkg::MODE_HIGHEST: begin
            if (!sts.empty) begin
              cmd.scan_first = 1'b1;
              state_next     = S_SCAN;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_READ: begin
        cmd.take_pop = 1'b1;
        state_next   = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sws_dp.sv =====
// ----------------------------------------------------------------------------
// sws_dp
// datapath: fill count, entry ram, scan compare and result register
// ----------------------------------------------------------------------------
module sws_dp #(
  parameter int STACK_DEPTH = 16,
  parameter int NAME_BYTES  = 8,
  localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
  localparam int CW    = $clog2(STACK_DEPTH + 1),
  localparam int KEY_W = 8 * NAME_BYTES
) (
  input  logic          clk,
  input  logic          rst,
  sws_req_if.sink       request,
  sws_res_if.source     result,
  input  sws_pkg::cmd_t cmd,
  output sws_pkg::sts_t sts
);

  localparam int ENT_W = KEY_W + sws_pkg::VALUE_W;

  logic [CW-1:0]                       fill;
  logic [CW-1:0]                       fill_dec;
  logic [CW-1:0]                       idx;
  logic [sws_pkg::MODE_W-1:0]          mode;
  logic [KEY_W-1:0]                    key;
  logic signed [sws_pkg::VALUE_W-1:0]  value;
  logic                                err_empty;
  logic                                err_full;
  logic                                found;
  logic [KEY_W-1:0]                    best_key;
  logic signed [sws_pkg::VALUE_W-1:0]  best_val;
  logic                                out_valid;
  logic [sws_pkg::STAT_W-1:0]          res_status;
  logic [sws_pkg::NAME_W-1:0]          res_name;
  logic signed [sws_pkg::VALUE_W-1:0]  res_value;
  logic [CW-1:0]                       res_depth;

  logic                                accept;
  logic                                is_empty;
  logic                                is_full;
  logic [AW-1:0]                       ram_addr;
  logic [ENT_W-1:0]                    ram_rdata;
  logic [KEY_W-1:0]                    rd_key;
  logic signed [sws_pkg::VALUE_W-1:0]  rd_val;
  logic                                better;
  logic                                take;
  logic [sws_pkg::STAT_W-1:0]          status_next;

  assign accept   = cmd.ready && request.valid;
  assign is_empty = (fill == '0);
  assign is_full  = (fill == CW'(STACK_DEPTH));
  assign fill_dec = fill - 1'b1;
  assign rd_key   = ram_rdata[ENT_W-1:sws_pkg::VALUE_W];
  assign rd_val   = ram_rdata[sws_pkg::VALUE_W-1:0];

  always_comb begin
    ram_addr = idx[AW-1:0];
    if (cmd.push) begin
      ram_addr = fill[AW-1:0];
    end else if (cmd.pop) begin
      ram_addr = fill_dec[AW-1:0];
    end else if (cmd.scan_first) begin
      ram_addr = '0;
    end
  end

  sws_ram #(
    .WIDTH (ENT_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .addr  (ram_addr),
    .wdata ({key, value}),
    .rdata (ram_rdata)
  );

  // lowest/highest keep the first extreme from the bottom
  always_comb begin
    better = (mode == sws_pkg::MODE_LOWEST) ? (rd_val < best_val) : (rd_val > best_val);
    if (mode == sws_pkg::MODE_SEARCH) begin
      take = !found && (rd_key == key);
    end else begin
      take = !found || better;
    end
  end

  always_comb begin
    if (err_full) begin
      status_next = sws_pkg::ST_FULL;
    end else if (err_empty) begin
      status_next = sws_pkg::ST_EMPTY;
    end else if (mode == sws_pkg::MODE_SEARCH && !found) begin
      status_next = sws_pkg::ST_MISSING;
    end else begin
      status_next = sws_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
      found     <= 1'b0;
      err_empty <= 1'b0;
      err_full  <= 1'b0;
      idx       <= '0;
    end else begin
      if (accept) begin
        mode  <= request.mode;
        key   <= request.name_key[KEY_W-1:0];
        value <= request.value_in;
        found <= 1'b0;
      end
      if (cmd.exec) begin
        err_empty <= is_empty && (mode == sws_pkg::MODE_POP || mode == sws_pkg::MODE_SEARCH ||
                                  mode == sws_pkg::MODE_LOWEST || mode == sws_pkg::MODE_HIGHEST);
        err_full  <= is_full && (mode == sws_pkg::MODE_PUSH);
      end
      if (cmd.push) begin
        fill <= fill + 1'b1;
      end
      if (cmd.pop) begin
        fill <= fill_dec;
      end
      if (cmd.take_pop) begin
        found    <= 1'b1;
        best_key <= rd_key;
        best_val <= rd_val;
      end
      if (cmd.scan_first) begin
        idx <= CW'(1);
      end
      if (cmd.scan_step) begin
        if (take) begin
          found    <= 1'b1;
          best_key <= rd_key;
          best_val <= rd_val;
        end
        if (idx != fill) begin
          idx <= idx + 1'b1;
        end
      end
      if (cmd.load) begin
        out_valid  <= 1'b1;
        res_status <= status_next;
        res_name   <= found ? sws_pkg::NAME_W'(best_key) : '0;
        res_value  <= found ? best_val : '0;
        res_depth  <= fill;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign request.ready    = cmd.ready;
  assign result.valid     = out_valid;
  assign result.status    = res_status;
  assign result.name_out  = res_name;
  assign result.value_out = res_value;
  assign result.depth     = res_depth;

  always_comb begin
    sts.mode      = mode;
    sts.req_valid = request.valid;
    sts.empty     = is_empty;
    sts.full      = is_full;
    sts.scan_last = (idx == fill);
    sts.out_free  = !out_valid || result.ready;
  end

endmodule
